@@ src/lpg_pkg.sv @@
// ----------------------------------------------------------------------------
// Lexicographic permutation generator package
// Shared widths, element type and sequencer states.
// ----------------------------------------------------------------------------
package lpg_pkg;

   localparam int MAX_LEN = 8;
   localparam int ELEM_W  = 3;
   localparam int IDX_W   = 3;
   localparam int LEN_W   = 4;
   localparam int PERM_W  = 24;
   localparam int RANK_W  = 16;

   typedef logic [ELEM_W-1:0] elem_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIND,
      ST_REV
   } state_type;

endpackage

@@ src/lpg_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel
// Carries one request item: the restart flag.
// ----------------------------------------------------------------------------
interface lpg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

@@ src/lpg_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response channel
// Carries one result item: packed permutation, rank and last flag.
// ----------------------------------------------------------------------------
interface lpg_rsp_if import lpg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PERM_W-1:0] permutation;
   logic [RANK_W-1:0] perm_index;
   logic              last;

   modport source (output valid, output permutation, output perm_index, output last,
                   input ready);
   modport sink   (input valid, input permutation, input perm_index, input last,
                   output ready);
endinterface

@@ src/lpg_csr_if.sv @@
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries the write data of the permutation length register.
// ----------------------------------------------------------------------------
interface lpg_csr_if import lpg_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ src/lexicographic_permutation_generator.sv @@
// ----------------------------------------------------------------------------
// Lexicographic permutation generator
// Emits the permutations of 0..n-1 in lexicographic order, one per request.
// ----------------------------------------------------------------------------
//   channel   direction   contents
//   req_bus   in          restart
//   rsp_bus   out         permutation, perm_index, last
//   csr_bus   in          perm_length write data
//
// A result is registered in the cycle after its request is taken. The
// next-permutation step then runs on one shared comparator: a pivot scan,
// a successor search that also swaps, and a suffix reversal; after the
// last permutation the sequence returns to the identity instead. Reset is
// synchronous and gives the identity, rank 0 and length 8. A request waits
// while the step runs and while the output register holds a result that
// has not been taken.
// ----------------------------------------------------------------------------
module lexicographic_permutation_generator import lpg_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   lpg_req_if.sink  req_bus,
   lpg_rsp_if.source rsp_bus,
   lpg_csr_if.sink  csr_bus
);

   state_type         state_ff, state_in;
   elem_type          perm_ff [MAX_LEN];
   elem_type          perm_in [MAX_LEN];
   logic [IDX_W-1:0]  ia_ff, ia_in;
   logic [IDX_W-1:0]  ib_ff, ib_in;
   logic [RANK_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PERM_W-1:0] rsp_perm_ff, rsp_perm_in;
   logic [RANK_W-1:0] rsp_index_ff, rsp_index_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [LEN_W-1:0]  n_eff;
   logic [IDX_W-1:0]  n_last;
   elem_type          src [MAX_LEN];
   logic              last_c;
   logic [PERM_W-1:0] packed_c;
   logic [RANK_W-1:0] rank_c;
   elem_type          op_a, op_b;
   logic              op_lt;
   logic              req_take;

   assign req_bus.ready       = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_take            = req_bus.valid && req_bus.ready;
   assign csr_bus.ready       = 1'b1;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.permutation = rsp_perm_ff;
   assign rsp_bus.perm_index  = rsp_index_ff;
   assign rsp_bus.last        = rsp_last_ff;

   always_comb begin
      if (len_ff == '0) begin
         n_eff = LEN_W'(1);
      end else if (len_ff > LEN_W'(MAX_LEN)) begin
         n_eff = LEN_W'(MAX_LEN);
      end else begin
         n_eff = len_ff;
      end
      n_last = IDX_W'(n_eff - LEN_W'(1));

      for (int k = 0; k < MAX_LEN; k++) begin
         src[k] = req_bus.restart ? ELEM_W'(k) : perm_ff[k];
      end

      last_c   = 1'b1;
      packed_c = '0;
      for (int k = 0; k < MAX_LEN; k++) begin
         if (LEN_W'(k) < n_eff) begin
            packed_c[k*ELEM_W +: ELEM_W] = src[k];
         end
      end
      for (int k = 1; k < MAX_LEN; k++) begin
         if (LEN_W'(k) < n_eff && src[k-1] < src[k]) begin
            last_c = 1'b0;
         end
      end
      rank_c = req_bus.restart ? '0 : count_ff;

      op_a = '0;
      op_b = '0;
      case (state_ff)
         ST_SCAN: begin
            op_a = perm_ff[ia_ff - IDX_W'(1)];
            op_b = perm_ff[ia_ff];
         end
         ST_FIND: begin
            op_a = perm_ff[ib_ff];
            op_b = perm_ff[ia_ff];
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
      op_lt = op_a < op_b;

      state_in     = state_ff;
      perm_in      = perm_ff;
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      count_in     = count_ff;
      len_in       = csr_bus.valid ? csr_bus.data : len_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_perm_in  = rsp_perm_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               rsp_valid_in = 1'b1;
               rsp_perm_in  = packed_c;
               rsp_index_in = rank_c;
               rsp_last_in  = last_c;
               if (last_c) begin
                  for (int k = 0; k < MAX_LEN; k++) begin
                     perm_in[k] = ELEM_W'(k);
                  end
                  count_in = '0;
               end else begin
                  perm_in  = src;
                  count_in = rank_c + RANK_W'(1);
                  ia_in    = n_last;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (op_lt) begin
               ib_in    = ia_ff - IDX_W'(1);
               ia_in    = n_last;
               state_in = ST_FIND;
            end else begin
               ia_in = ia_ff - IDX_W'(1);
            end
         end
         ST_FIND: begin
            if (op_lt) begin
               perm_in[ib_ff] = perm_ff[ia_ff];
               perm_in[ia_ff] = perm_ff[ib_ff];
               ia_in          = ib_ff + IDX_W'(1);
               ib_in          = n_last;
               state_in       = ST_REV;
            end else begin
               ia_in = ia_ff - IDX_W'(1);
            end
         end
         ST_REV: begin
            if (ia_ff < ib_ff) begin
               perm_in[ia_ff] = perm_ff[ib_ff];
               perm_in[ib_ff] = perm_ff[ia_ff];
               ia_in          = ia_ff + IDX_W'(1);
               ib_in          = ib_ff - IDX_W'(1);
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         len_ff       <= LEN_W'(MAX_LEN);
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_LEN; k++) begin
            perm_ff[k] <= ELEM_W'(k);
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
         perm_ff      <= perm_in;
      end
   end

   always_ff @(posedge clock) begin
      ia_ff        <= ia_in;
      ib_ff        <= ib_in;
      rsp_perm_ff  <= rsp_perm_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

@@ dv/lexicographic_permutation_generator_test.sv @@
// ----------------------------------------------------------------------------
// Lexicographic permutation generator testbench
// Drives restart requests and length register writes with random idle
// bursts on requests and responses, predicts every result in a scoreboard
// and compares each response item field by field in order of arrival.
// ----------------------------------------------------------------------------
module lexicographic_permutation_generator_test import lpg_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 600;
   localparam int SETTLE       = 2 * MAX_LEN + MAX_LEN / 2 + 20;
   localparam int QUIET_LIMIT  = 2000;

   typedef struct {
      logic [PERM_W-1:0] permutation;
      logic [RANK_W-1:0] perm_index;
      logic              last;
   } perm_result_type;

   class perm_scoreboard;
      elem_type          seq [MAX_LEN];
      logic [RANK_W-1:0] rank;
      logic [LEN_W-1:0]  length_reg;
      perm_result_type   expected_q [$];
      int                errors;
      int                requests;
      int                restarts;
      int                wraps;

      function void reset_state();
         for (int k = 0; k < MAX_LEN; k++) seq[k] = elem_type'(k);
         rank = '0;
         length_reg = LEN_W'(MAX_LEN);
         errors = 0;
         requests = 0;
         restarts = 0;
         wraps = 0;
      endfunction

      function void write_length(logic [LEN_W-1:0] value);
         length_reg = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Steps the first n entries to their successor; returns 1 when none follows.
      function logic step_sequence(int n);
         int       p;
         int       q;
         int       lo;
         int       hi;
         elem_type t;
         p = n;
         for (int k = n - 1; k > 0; k--) begin
            if (seq[k-1] < seq[k]) begin
               p = k - 1;
               break;
            end
         end
         if (p == n) return 1'b1;
         q = n - 1;
         while (q > p && seq[q] <= seq[p]) q--;
         t = seq[p];
         seq[p] = seq[q];
         seq[q] = t;
         lo = p + 1;
         hi = n - 1;
         while (lo < hi) begin
            t = seq[lo];
            seq[lo] = seq[hi];
            seq[hi] = t;
            lo++;
            hi--;
         end
         return 1'b0;
      endfunction

      function void note_request(logic restart);
         int              n;
         perm_result_type r;
         n = int'(length_reg);
         if (n < 1) n = 1;
         if (n > MAX_LEN) n = MAX_LEN;
         requests++;
         if (restart) begin
            restarts++;
            for (int k = 0; k < MAX_LEN; k++) seq[k] = elem_type'(k);
            rank = '0;
         end
         r.permutation = '0;
         for (int k = 0; k < n; k++)
            r.permutation = r.permutation | (PERM_W'(seq[k]) << (ELEM_W * k));
         r.perm_index = rank;
         r.last = step_sequence(n);
         if (r.last) begin
            wraps++;
            for (int k = 0; k < MAX_LEN; k++) seq[k] = elem_type'(k);
            rank = '0;
         end else begin
            rank = rank + 1'b1;
         end
         expected_q.push_back(r);
      endfunction

      function void check_result(logic [PERM_W-1:0] permutation,
                                 logic [RANK_W-1:0] perm_index, logic last);
         perm_result_type e;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("Unexpected result: perm %06h rank %0d last %0b",
                        permutation, perm_index, last);
            return;
         end
         e = expected_q.pop_front();
         if (permutation !== e.permutation || perm_index !== e.perm_index ||
             last !== e.last) begin
            errors++;
            if (errors <= 10) begin
               $display("Result mismatch: expected perm %06h rank %0d last %0b,",
                        e.permutation, e.perm_index, e.last);
               $display("   got perm %06h rank %0d last %0b",
                        permutation, perm_index, last);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic idle_on;
   int   stall_left;
   int   quiet_cycles;
   int   lengths_set;

   perm_scoreboard sb = new();

   lpg_req_if req_if ();
   lpg_rsp_if rsp_if ();
   lpg_csr_if csr_if ();

   lexicographic_permutation_generator dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) sb.note_request(req_if.restart);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.permutation, rsp_if.perm_index, rsp_if.last);
         if (csr_if.valid && csr_if.ready) sb.write_length(csr_if.data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles.", QUIET_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      rsp_if.ready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_if.ready = 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_if.ready = 1'b0;
            stall_left = $urandom_range(1, 13) - 1;
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   task automatic send_request(input logic restart);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 13) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid = 1'b1;
      req_if.restart = restart;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic drain();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_length(input logic [LEN_W-1:0] value);
      drain();
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.data = value;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid = 1'b0;
      lengths_set++;
   endtask

   initial begin
      int               sent;
      int               phase_items;
      int               pick;
      logic [LEN_W-1:0] len;
      sb.reset_state();
      reset = 1'b1;
      idle_on = 1'b1;
      lengths_set = 0;
      req_if.valid = 1'b0;
      req_if.restart = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b0);
      set_length(LEN_W'(1));
      repeat (2) send_request(1'b0);
      set_length(LEN_W'(3));
      repeat (7) send_request(1'b0);
      set_length('0);
      send_request(1'b0);
      set_length('1);
      repeat (2) send_request(1'b0);
      set_length(LEN_W'(3));
      send_request(1'b1);
      repeat (2) send_request(1'b0);
      set_length(LEN_W'(2));
      repeat (2) send_request(1'b0);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         idle_on = (sent < RANDOM_ITEMS - 60) && ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 19);
         if (pick < 12) len = LEN_W'($urandom_range(1, 5));
         else if (pick < 16) len = LEN_W'($urandom_range(6, 8));
         else if (pick < 18) len = LEN_W'($urandom_range(9, 15));
         else len = '0;
         set_length(len);
         if ($urandom_range(0, 7) == 0) phase_items = $urandom_range(100, 130);
         else phase_items = $urandom_range(4, 40);
         for (int i = 0; i < phase_items && sent < RANDOM_ITEMS; i++) begin
            if (i == 0) send_request(logic'($urandom_range(0, 1)));
            else send_request($urandom_range(0, 15) == 0);
            sent++;
         end
      end

      idle_on = 1'b0;
      drain();
      sb.errors = sb.errors + sb.pending();
      $display("Covered %0d requests over %0d length settings, with %0d restarts and %0d wraps.",
               sb.requests, lengths_set, sb.restarts, sb.wraps);
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
